/* sv/nfaw_pkg.sv */
// Shared types and constants for the automaton word acceptor.
// No dependencies; imported by every module of the block.
package nfaw_pkg;

  // Field widths fixed by the word format
  localparam int unsigned STATE_W = 4;
  localparam int unsigned LABEL_W = 5;
  localparam int unsigned MASK_W  = 16;

  // Word actions
  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SYMBOL = 2'd1,
    ACT_EMPTY  = 2'd2
  } action_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 1'd1;

  // One input word as held in the processing stage
  typedef struct packed {
    action_e            action;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [LABEL_W-1:0] edge_label;
    logic [LABEL_W-1:0] symbol;
    logic               last;
  } item_t;

  // Edge table write request
  typedef struct packed {
    logic               en;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [LABEL_W-1:0] label;
  } edge_wr_t;

  // Result produced by the processing stage
  typedef struct packed {
    logic valid;
    logic accepted;
  } result_t;

endpackage

/* sv/nfa_word_acceptor_unit.sv */
// Top level of the automaton word acceptor: stream ports, input and output registers,
// configuration registers. Depends on nfaw_pkg and nfaw_word_ctrl.
//
// In the processing stage, edge writes update the register table, symbols step the
// whole active set at once by comparing every table cell in parallel, and a last
// symbol or an empty-word request loads the accept flag into the output register.
// One word per cycle is sustained while the result side keeps up. A word that
// yields a result stalls in the stage only while the previous result still waits
// unaccepted; other words pass it. Result valid comes from the output register,
// loaded when the word leaves the input register. Write configuration only when
// idle.
module nfa_word_acceptor_unit
  import nfaw_pkg::*;
#(
  parameter int unsigned NUM_STATES    = 16,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MASK_W-1:0]    cfg_data_i,
  // Input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [1:0] action, [5:2] from_state, [9:6] to_state, [14:10] edge_label,
  // [19:15] symbol, [23:20] zero
  input  logic [23:0]          s_axis_tdata_i,
  input  logic                 s_axis_tlast_i,
  // Result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [0] accepted, [7:1] zero
  output logic [7:0]           m_axis_tdata_o
);

  logic [STATE_W-1:0] start_state_q;
  logic [MASK_W-1:0]  final_mask_q;
  item_t              item_q;
  logic               item_vld_q;
  logic               step;
  result_t            result;
  logic               out_vld_q;
  logic               out_acc_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= '0;
      final_mask_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_STATE: start_state_q <= cfg_data_i[STATE_W-1:0];
        CFG_FINAL_MASK:  final_mask_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Stage advances unless its result would overwrite one still waiting
  assign step = item_vld_q && (!result.valid || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !item_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      item_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.action     <= action_e'(s_axis_tdata_i[1:0]);
      item_q.from_state <= s_axis_tdata_i[5:2];
      item_q.to_state   <= s_axis_tdata_i[9:6];
      item_q.edge_label <= s_axis_tdata_i[14:10];
      item_q.symbol     <= s_axis_tdata_i[19:15];
      item_q.last       <= s_axis_tlast_i;
    end
  end

  nfaw_word_ctrl #(
    .NUM_STATES   (NUM_STATES),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (item_q),
    .start_state_i(start_state_q),
    .final_mask_i (final_mask_q),
    .result_o     (result)
  );

  // Output register: load a new result, drop a taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && result.valid) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && result.valid) begin
      out_acc_q <= result.accepted;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, out_acc_q};

endmodule

/* sv/nfaw_edge_table.sv */
// Register table of edge labels, one cell per (from, to) state pair.
// Computes the next active set for a symbol. Depends on nfaw_pkg.
module nfaw_edge_table
  import nfaw_pkg::*;
#(
  parameter int unsigned NUM_STATES    = 16,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  edge_wr_t              wr_i,
  input  logic [NUM_STATES-1:0] cur_set_i,
  input  logic [LABEL_W-1:0]    symbol_i,
  output logic [NUM_STATES-1:0] next_set_o
);

  logic [LABEL_W-1:0] label_q   [NUM_STATES][NUM_STATES];
  logic               present_q [NUM_STATES][NUM_STATES];
  logic               wr_present;

  // A label outside the alphabet marks the edge absent
  assign wr_present = 32'(wr_i.label) < ALPHABET_SIZE;

  for (genvar s = 0; s < NUM_STATES; s++) begin : g_row
    for (genvar t = 0; t < NUM_STATES; t++) begin : g_col
      logic hit;
      assign hit = wr_i.en && (32'(wr_i.from_state) == s) && (32'(wr_i.to_state) == t);

      // Presence bits clear on reset
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          present_q[s][t] <= 1'b0;
        end else if (hit) begin
          present_q[s][t] <= wr_present;
        end
      end

      // Label payload
      always_ff @(posedge clk_i) begin
        if (hit) begin
          label_q[s][t] <= wr_i.label;
        end
      end
    end
  end

  // Gather every target reached from an active state on a matching edge
  always_comb begin
    next_set_o = '0;
    for (int unsigned t = 0; t < NUM_STATES; t++) begin
      for (int unsigned s = 0; s < NUM_STATES; s++) begin
        if (cur_set_i[s] && present_q[s][t] && (label_q[s][t] == symbol_i)) begin
          next_set_o[t] = 1'b1;
        end
      end
    end
  end

endmodule

/* sv/nfaw_word_ctrl.sv */
// Word tracking: active state set, word-in-progress flag and acceptance test.
// Drives the edge table. Depends on nfaw_pkg and nfaw_edge_table.
module nfaw_word_ctrl
  import nfaw_pkg::*;
#(
  parameter int unsigned NUM_STATES    = 16,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  item_t              item_i,
  input  logic [STATE_W-1:0] start_state_i,
  input  logic [MASK_W-1:0]  final_mask_i,
  output result_t            result_o
);

  logic [NUM_STATES-1:0] active_q, active_d;
  logic                  in_word_q, in_word_d;
  logic [NUM_STATES-1:0] start_set, cur_set, next_set;
  logic [63:0]           mask_ext;
  logic                  acc_next, acc_start;
  edge_wr_t              wr;

  assign mask_ext = 64'(final_mask_i);

  // Starting set and acceptance checks
  always_comb begin
    start_set = '0;
    acc_next  = 1'b0;
    acc_start = 1'b0;
    for (int unsigned s = 0; s < NUM_STATES; s++) begin
      start_set[s] = (32'(start_state_i) == s);
    end
    for (int unsigned s = 0; s < NUM_STATES; s++) begin
      acc_next  = acc_next  | (next_set[s]  & mask_ext[s]);
      acc_start = acc_start | (start_set[s] & mask_ext[s]);
    end
  end

  // A new word starts from the start state alone
  assign cur_set = in_word_q ? active_q : start_set;

  // Edge writes go straight to the table
  always_comb begin
    wr.en         = step_i && (item_i.action == ACT_WRITE);
    wr.from_state = item_i.from_state;
    wr.to_state   = item_i.to_state;
    wr.label      = item_i.edge_label;
  end

  nfaw_edge_table #(
    .NUM_STATES   (NUM_STATES),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .cur_set_i (cur_set),
    .symbol_i  (item_i.symbol),
    .next_set_o(next_set)
  );

  // Advance the word and decide the result
  always_comb begin
    active_d        = active_q;
    in_word_d       = in_word_q;
    result_o.valid    = 1'b0;
    result_o.accepted = 1'b0;
    case (item_i.action)
      ACT_SYMBOL: begin
        if (item_i.last) begin
          result_o.valid    = 1'b1;
          result_o.accepted = acc_next;
          active_d          = '0;
          in_word_d         = 1'b0;
        end else begin
          active_d  = next_set;
          in_word_d = 1'b1;
        end
      end
      ACT_EMPTY: begin
        result_o.valid    = 1'b1;
        result_o.accepted = acc_start;
        active_d          = '0;
        in_word_d         = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Hold word state until the stage advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      in_word_q <= 1'b0;
    end else if (step_i) begin
      active_q  <= active_d;
      in_word_q <= in_word_d;
    end
  end

endmodule
